### rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, codes and kernel tables of the toroidal 3x3 convolution core.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_SIDE   = 2'd0;
    localparam logic [1:0] CFG_IDX_KERNEL = 2'd1;

    localparam logic [6:0] SIDE_RESET   = 7'd64;
    localparam logic [2:0] KERNEL_RESET = 3'd0;

    // kernel select codes
    localparam logic [2:0] KSEL_FOCUS   = 3'd0;
    localparam logic [2:0] KSEL_ENHANCE = 3'd1;
    localparam logic [2:0] KSEL_DETECT  = 3'd2;
    localparam logic [2:0] KSEL_SOBEL   = 3'd3;
    localparam logic [2:0] KSEL_SHARPEN = 3'd4;

    // window taps, row-major from the upper left neighbour
    localparam logic [3:0] TAP_FIRST  = 4'd0;
    localparam logic [3:0] TAP_CENTER = 4'd4;
    localparam logic [3:0] TAP_LAST   = 4'd8;

    // neighbour offset codes
    localparam logic [1:0] OFS_MINUS  = 2'd0;
    localparam logic [1:0] OFS_CENTER = 2'd1;
    localparam logic [1:0] OFS_PLUS   = 2'd2;

    localparam logic signed [9:0] CONV_MAX = 10'sd511;
    localparam logic signed [9:0] CONV_MIN = -10'sd512;

    localparam logic signed [3:0] K_FOCUS [9] =
        '{4'sd0, -4'sd1, 4'sd0, -4'sd1, 4'sd5, 4'sd1, 4'sd0, -4'sd1, 4'sd0};
    localparam logic signed [3:0] K_ENHANCE [9] =
        '{4'sd0, 4'sd0, 4'sd0, -4'sd1, 4'sd1, 4'sd0, 4'sd0, 4'sd0, 4'sd0};
    localparam logic signed [3:0] K_DETECT [9] =
        '{4'sd0, 4'sd1, 4'sd0, 4'sd1, -4'sd4, 4'sd1, 4'sd0, 4'sd1, 4'sd0};
    localparam logic signed [3:0] K_SOBEL [9] =
        '{-4'sd1, 4'sd0, 4'sd1, -4'sd2, 4'sd0, 4'sd2, -4'sd1, 4'sd0, 4'sd1};
    localparam logic signed [3:0] K_SHARPEN [9] =
        '{4'sd1, -4'sd2, 4'sd1, -4'sd2, 4'sd5, -4'sd2, 4'sd1, -4'sd2, 4'sd1};

    typedef struct packed {
        logic       capture;      // take the input beat into the work registers
        logic       mem_wr;       // store the pixel at the center tap
        logic       mem_rd;       // read the neighbour at tap
        logic [3:0] tap;
        logic       result_load;  // move the saturated sum into the output register
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_compute;
        logic in_range;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [3:0] kernel_coeff(input logic [2:0] sel,
                                                       input logic [3:0] tap);
        logic signed [3:0] c;
        c = '0;
        if (tap <= TAP_LAST) begin
            case (sel)
                KSEL_FOCUS:   c = K_FOCUS[tap];
                KSEL_ENHANCE: c = K_ENHANCE[tap];
                KSEL_DETECT:  c = K_DETECT[tap];
                KSEL_SOBEL:   c = K_SOBEL[tap];
                KSEL_SHARPEN: c = K_SHARPEN[tap];
                default:      c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic logic [1:0] tap_row_ofs(input logic [3:0] tap);
        logic [1:0] o;
        case (tap) inside
            4'd0, 4'd1, 4'd2: o = OFS_MINUS;
            4'd3, 4'd4, 4'd5: o = OFS_CENTER;
            default:          o = OFS_PLUS;
        endcase
        return o;
    endfunction

    function automatic logic [1:0] tap_col_ofs(input logic [3:0] tap);
        logic [1:0] o;
        case (tap) inside
            4'd0, 4'd3, 4'd6: o = OFS_MINUS;
            4'd1, 4'd4, 4'd7: o = OFS_CENTER;
            default:          o = OFS_PLUS;
        endcase
        return o;
    endfunction

endpackage

### rtl/core/toroidal_3x3_convolution_core.sv
// ----------------------------------------------------------------------------
// toroidal_3x3_convolution_core
// 3x3 convolution over a wrap-around image held in an on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   slave stream: one beat per command. tuser = 0 stores tdata's pixel at
//   (row, col); tuser = 1 asks for the weighted 3x3 sum centred at (row, col).
//   Coordinates at or above the active side drop a store and give a zero sum.
//   master stream: one beat with conv_value per compute command, in order.
//   config channel: index 0 image side (1..IMG_SIDE, 0 or larger = IMG_SIDE),
//   index 1 kernel select; always ready, write only while the core is idle.
// Timing:
//   a store passes through decode, where the pixel is written. A compute reads
//   its nine neighbours from the single-port image memory one per cycle; its
//   result shows on the master side and the core is ready again in the same
//   cycle. An out-of-range compute goes straight from decode to the result.
// Reset and stall:
//   reset restores the side to 64 and the kernel to focus; pixels stay
//   undefined until stored. A finished result waits in the output register;
//   stores are still taken meanwhile, a further compute holds until it drains.
// ----------------------------------------------------------------------------
module toroidal_3x3_convolution_core #(
    parameter int IMG_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // row[5:0], col[11:6], pixel[17:12], zero[23:18]
    input  logic        i_s_tuser,   // cmd[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // conv_value[9:0], zero[15:10]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    tcc_pkg::t_ctrl_cmd  cmd;
    tcc_pkg::t_dp_status status;
    logic signed [9:0]   conv_value;

    tcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcc_datapath #(
        .IMG_SIDE (IMG_SIDE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_in_cmd     (i_s_tuser),
        .i_in_row     (i_s_tdata[5:0]),
        .i_in_col     (i_s_tdata[11:6]),
        .i_in_pixel   (i_s_tdata[17:12]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_conv_value (conv_value)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {6'd0, conv_value};

endmodule

### rtl/core/tcc_ctrl.sv
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer: accepts beats, issues the pixel write or the nine window reads
// and hands the finished sum to the output register.
// ----------------------------------------------------------------------------
module tcc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  tcc_pkg::t_dp_status   i_status,
    output tcc_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_READ   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_tap, n_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= tcc_pkg::TAP_FIRST;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state           = r_state;
        n_tap             = r_tap;
        o_cmd             = '0;
        o_cmd.tap         = r_tap;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_s_tvalid;
                n_tap         = tcc_pkg::TAP_FIRST;
                if (i_s_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.tap = tcc_pkg::TAP_CENTER;
                if (!i_status.is_compute) begin
                    o_cmd.mem_wr = i_status.in_range;
                    n_state      = S_IDLE;
                end else if (i_status.in_range) begin
                    n_state = S_READ;
                end else begin
                    // outside the image: sum stays cleared
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_tap        = r_tap + 4'd1;
                if (r_tap == tcc_pkg::TAP_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result_load |-> i_status.out_free)
        else $error("result loaded while output register busy");

    a_read_only_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_rd |-> (i_status.is_compute && i_status.in_range && !o_cmd.mem_wr))
        else $error("window read outside an in-range compute");

    a_write_only_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_wr |-> (!i_status.is_compute && i_status.in_range &&
                          o_cmd.tap == tcc_pkg::TAP_CENTER))
        else $error("pixel write outside an in-range store");

    a_read_follows_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.mem_rd && r_tap == tcc_pkg::TAP_FIRST) |-> $past(r_state == S_DECODE))
        else $error("window walk started without decode");
`endif

endmodule

### rtl/core/tcc_datapath.sv
// ----------------------------------------------------------------------------
// tcc_datapath
// Image memory, toroidal address generation, multiply-accumulate, saturation,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module tcc_datapath #(
    parameter int IMG_SIDE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcc_pkg::t_ctrl_cmd    i_cmd,
    output tcc_pkg::t_dp_status   o_status,
    input  logic                  i_in_cmd,
    input  logic [5:0]            i_in_row,
    input  logic [5:0]            i_in_col,
    input  logic signed [5:0]     i_in_pixel,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [6:0]            i_cfg_data,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic signed [9:0]     o_conv_value
);

    localparam int DEPTH = IMG_SIDE * IMG_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(IMG_SIDE + 1);
    localparam int EW    = (SW > 7) ? SW : 7;

    // configuration
    logic [6:0] r_side;
    logic [2:0] r_ksel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= tcc_pkg::SIDE_RESET;
            r_ksel <= tcc_pkg::KERNEL_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tcc_pkg::CFG_IDX_SIDE) begin
                r_side <= i_cfg_data;
            end else if (i_cfg_index == tcc_pkg::CFG_IDX_KERNEL) begin
                r_ksel <= i_cfg_data[2:0];
            end
        end
    end

    // work registers
    logic              r_is_compute;
    logic [5:0]        r_row;
    logic [5:0]        r_col;
    logic signed [5:0] r_pixel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_compute <= i_in_cmd;
            r_row        <= i_in_row;
            r_col        <= i_in_col;
            r_pixel      <= i_in_pixel;
        end
    end

    // active side, zero or oversize means full image
    logic [EW-1:0] side_reg_ext;
    logic [EW-1:0] side;
    logic [EW-1:0] row_ext, col_ext;
    logic          in_range;

    assign side_reg_ext = EW'(r_side);
    assign side = (r_side == 7'd0 || side_reg_ext > EW'(IMG_SIDE)) ? EW'(IMG_SIDE)
                                                                  : side_reg_ext;
    assign row_ext  = EW'(r_row);
    assign col_ext  = EW'(r_col);
    assign in_range = (row_ext < side) && (col_ext < side);

    // wrap-around neighbours
    logic [EW-1:0] row_m1, row_p1, col_m1, col_p1;
    logic [EW-1:0] row_sel, col_sel;
    logic [AW-1:0] addr;

    assign row_m1 = (row_ext == '0) ? side - EW'(1) : row_ext - EW'(1);
    assign row_p1 = (row_ext + EW'(1) == side) ? '0 : row_ext + EW'(1);
    assign col_m1 = (col_ext == '0) ? side - EW'(1) : col_ext - EW'(1);
    assign col_p1 = (col_ext + EW'(1) == side) ? '0 : col_ext + EW'(1);

    always_comb begin
        case (tcc_pkg::tap_row_ofs(i_cmd.tap))
            tcc_pkg::OFS_MINUS:  row_sel = row_m1;
            tcc_pkg::OFS_CENTER: row_sel = row_ext;
            default:             row_sel = row_p1;
        endcase
        case (tcc_pkg::tap_col_ofs(i_cmd.tap))
            tcc_pkg::OFS_MINUS:  col_sel = col_m1;
            tcc_pkg::OFS_CENTER: col_sel = col_ext;
            default:             col_sel = col_p1;
        endcase
    end

    assign addr = AW'(row_sel) * AW'(IMG_SIDE) + AW'(col_sel);

    // single-port image memory
    logic signed [5:0] mem [DEPTH];
    logic signed [5:0] r_rd_data;
    logic              r_mac_en;
    logic [3:0]        r_mac_tap;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[addr] <= r_pixel;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= mem[addr];
        end
        r_mac_tap <= i_cmd.tap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_en <= 1'b0;
        end else begin
            r_mac_en <= i_cmd.mem_rd;
        end
    end

    // multiply-accumulate, one tap a cycle
    logic signed [3:0]  coeff;
    logic signed [11:0] prod;
    logic signed [11:0] r_acc;

    assign coeff = tcc_pkg::kernel_coeff(r_ksel, r_mac_tap);
    assign prod  = 12'(r_rd_data) * 12'(coeff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_acc <= '0;
        end else if (r_mac_en) begin
            r_acc <= r_acc + prod;
        end
    end

    logic signed [9:0] sat_value;

    always_comb begin
        if (r_acc > 12'(tcc_pkg::CONV_MAX)) begin
            sat_value = tcc_pkg::CONV_MAX;
        end else if (r_acc < 12'(tcc_pkg::CONV_MIN)) begin
            sat_value = tcc_pkg::CONV_MIN;
        end else begin
            sat_value = r_acc[9:0];
        end
    end

    // output register
    logic              r_out_valid;
    logic signed [9:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_out_data <= sat_value;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_conv_value = r_out_data;

    assign o_status.is_compute = r_is_compute;
    assign o_status.in_range   = in_range;
    assign o_status.out_free   = !r_out_valid || i_m_tready;

endmodule
